// ----- rtl/gta_pkg.sv -----
// Shared types and constants for the GELU (tanh form) pipeline.
// Used by gta_exp, gta_div and gelu_tanh_approx_top; no dependencies.
package gta_pkg;

  localparam int DataW = 16;

  // 0.044715 in Q.24 and 0.79788456 in Q.16
  localparam logic [19:0] KCUBE    = 20'd750193;
  localparam logic [15:0] KC1      = 16'd52290;
  // tanh argument at which tanh is taken as exactly one (8.0 in Q.12)
  localparam logic [18:0] TANH_SAT = 19'd32768;

  localparam int ExpStages = 15;
  localparam int DivStages = 31;

  // Per-item data that rides alongside the arithmetic
  typedef struct packed {
    logic        neg;
    logic        sat;
    logic [15:0] m;
  } side_t;

  // exp(-2^(idx-12)) in Q0.32, built by repeated rounded squaring
  function automatic logic [31:0] exp_coef(input int idx);
    logic [63:0] t;
    t = 64'd4293918848;
    for (int i = 0; i < idx; i++) begin
      t = (t * t + 64'h8000_0000) >> 32;
    end
    return t[31:0];
  endfunction

endpackage

// ----- rtl/gta_exp.sv -----
// Pipelined exp(-z) in Q0.32: one stage per bit of z, one multiply each.
// Depends on gta_pkg.
module gta_exp (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_vld,
  input  gta_pkg::side_t   in_side,
  input  logic [14:0]      zb,       // z bits 15..1 (z = 2a)
  output logic             out_vld,
  output gta_pkg::side_t   out_side,
  output logic             e_one,    // e is exactly 1.0
  output logic [31:0]      e
);

  localparam int N = gta_pkg::ExpStages;

  logic           vld  [1:N];
  gta_pkg::side_t side [1:N];
  logic           one  [1:N];
  logic [31:0]    ev   [1:N];
  logic [14:0]    zs   [1:N];

  for (genvar k = 1; k <= N; k++) begin : g_stage
    localparam logic [31:0] Coef = gta_pkg::exp_coef(k);
    logic           s_vld;
    gta_pkg::side_t s_side;
    logic           s_one;
    logic [31:0]    s_e;
    logic [14:0]    s_zb;
    logic [63:0]    prod;

    if (k == 1) begin : g_first
      assign s_vld  = in_vld;
      assign s_side = in_side;
      assign s_one  = 1'b1;
      assign s_e    = '0;
      assign s_zb   = zb;
    end else begin : g_rest
      assign s_vld  = vld[k-1];
      assign s_side = side[k-1];
      assign s_one  = one[k-1];
      assign s_e    = ev[k-1];
      assign s_zb   = zs[k-1];
    end

    assign prod = 64'(s_e) * 64'(Coef) + 64'h8000_0000;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= s_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side[k] <= s_side;
        zs[k]   <= s_zb;
        if (s_zb[k-1]) begin
          one[k] <= 1'b0;
          // scaling 1.0 by the coefficient is exact
          ev[k]  <= s_one ? Coef : prod[63:32];
        end else begin
          one[k] <= s_one;
          ev[k]  <= s_e;
        end
      end
    end
  end

  assign out_vld  = vld[N];
  assign out_side = side[N];
  assign e_one    = one[N];
  assign e        = ev[N];

endmodule

// ----- rtl/gta_div.sv -----
// Pipelined restoring divider: q = rnd(e * 2^31 / (2^32 + e)), one bit a stage.
// Depends on gta_pkg.
module gta_div (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_vld,
  input  gta_pkg::side_t   in_side,
  input  logic             e_one,
  input  logic [31:0]      e,
  output logic             out_vld,
  output gta_pkg::side_t   out_side,
  output logic [30:0]      q
);

  localparam int N = gta_pkg::DivStages;

  logic           vld  [0:N];
  gta_pkg::side_t side [0:N];
  logic [32:0]    rem  [0:N];
  logic [33:0]    den  [0:N];
  logic [30:0]    nlo  [0:N];
  logic [30:0]    quo  [0:N];

  logic [32:0] e_full;
  logic [33:0] den_c;
  logic [63:0] num;

  always_comb begin
    e_full = e_one ? 33'h1_0000_0000 : {1'b0, e};
    den_c  = 34'h1_0000_0000 + 34'(e_full);
    // round to nearest: add half the divisor
    num    = {e_full, 31'b0} + 64'(den_c >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= in_side;
      rem[0]  <= num[63:31];
      den[0]  <= den_c;
      nlo[0]  <= num[30:0];
      quo[0]  <= '0;
    end
  end

  for (genvar k = 1; k <= N; k++) begin : g_step
    logic [33:0] rs;
    logic        ge;

    assign rs = {rem[k-1], nlo[k-1][30]};
    assign ge = (rs >= den[k-1]);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side[k] <= side[k-1];
        den[k]  <= den[k-1];
        nlo[k]  <= {nlo[k-1][29:0], 1'b0};
        quo[k]  <= {quo[k-1][29:0], ge};
        rem[k]  <= ge ? 33'(rs - den[k-1]) : rs[32:0];
      end
    end
  end

  assign out_vld  = vld[N];
  assign out_side = side[N];
  assign q        = quo[N];

endmodule

// ----- rtl/gelu_tanh_approx_top.sv -----
// GELU, tanh approximation, on signed Q3.12 samples; uses gta_pkg, gta_exp, gta_div.
// Throughput: one request per cycle while the output is not stalled; the 31-stage
// divider and 15-stage exp chain set most of the depth. A waiting result (m_tvalid
// high, m_tready low) freezes every stage.
// Reset (rst, synchronous) clears all valid bits; data registers are not reset.
module gelu_tanh_approx_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] sample_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [15:0] gelu_out
);

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  logic [8:1]     vld;
  gta_pkg::side_t side [1:8];
  gta_pkg::side_t side_in;
  logic [15:0]    mag;

  logic [31:0] msq;
  logic [47:0] mcube;
  logic [33:0] c3;
  logic [53:0] kp;
  logic [18:0] u;
  logic [35:0] ap;
  logic [18:0] a;
  logic [18:0] a_next;

  always_comb begin
    // 16-bit wrap gives 32768 for the most negative sample
    mag     = s_tdata[15] ? (16'd0 - s_tdata) : s_tdata;
    side_in = '{neg: s_tdata[15], sat: 1'b0, m: mag};
    a_next  = 19'((ap + 36'd32768) >> 16);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[7:1], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[1] <= side_in;
      for (int k = 2; k <= 7; k++) begin
        side[k] <= side[k-1];
      end
      side[8] <= '{neg: side[7].neg,
                   sat: (a_next >= gta_pkg::TANH_SAT),
                   m:   side[7].m};

      msq   <= 32'(side[1].m) * 32'(side[1].m);
      mcube <= 48'(msq) * 48'(side[2].m);
      c3    <= 34'((mcube + 48'd2048) >> 12);
      kp    <= 54'(c3) * 54'(gta_pkg::KCUBE);
      u     <= 19'(side[5].m) + 19'((kp + (54'd1 << 35)) >> 36);
      ap    <= 36'(u) * 36'(gta_pkg::KC1);
      a     <= a_next;
    end
  end

  // exp(-2a), then d = 2e/(1+e) in Q0.30
  logic           x_vld;
  gta_pkg::side_t x_side;
  logic           x_one;
  logic [31:0]    x_e;

  gta_exp u_exp (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (vld[8]),
    .in_side  (side[8]),
    .zb       (a[14:0]),
    .out_vld  (x_vld),
    .out_side (x_side),
    .e_one    (x_one),
    .e        (x_e)
  );

  logic           d_vld;
  gta_pkg::side_t d_side;
  logic [30:0]    q;

  gta_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (x_vld),
    .in_side  (x_side),
    .e_one    (x_one),
    .e        (x_e),
    .out_vld  (d_vld),
    .out_side (d_side),
    .q        (q)
  );

  logic           vld9;
  gta_pkg::side_t side9;
  logic [46:0]    hp;
  logic [30:0]    d_eff;
  logic [15:0]    h;
  logic [15:0]    res;

  // tanh saturated: 1 - tanh is zero
  assign d_eff = d_side.sat ? '0 : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld9 <= 1'b0;
    end else if (en) begin
      vld9 <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side9 <= d_side;
      hp    <= 47'(d_side.m) * 47'(d_eff);
    end
  end

  always_comb begin
    h   = 16'((hp + (47'd1 << 30)) >> 31);
    res = side9.neg ? (16'd0 - h) : (side9.m - h);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vld9;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= res;
    end
  end

`ifndef SYNTHESIS
  // the correction term never exceeds the magnitude for a positive sample
  a_corr_bound: assert property (@(posedge clk) disable iff (rst)
    vld9 && !side9.neg |-> h <= side9.m)
    else $error("gelu: correction term above sample magnitude");

  // results never fall below -4.0 in Q3.12
  a_out_floor: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[15] && !m_tdata[14]))
    else $error("gelu: result below -16384");

  a_rst_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("gelu: result valid right after reset");
`endif

endmodule
